// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define MFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define MFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/mfd_pkg.sv
// Shared types and constants of the motor feedback decoder.
// No dependencies; imported by the controller, the datapath and the top level.
package mfd_pkg;

  // Turn bookkeeping.
  localparam logic [15:0]        TURN_MULT = 16'd8191;
  localparam logic signed [16:0] HALF_TURN = 17'sd4096;

  // Register reset values.
  localparam logic [12:0] RST_OFFSET    = 13'd0;
  localparam logic [16:0] ALPHA_ONE     = 17'd65536;
  localparam logic [23:0] RST_SPD_SCALE = 24'd65536;
  localparam logic [23:0] RST_POS_SCALE = 24'd524288;

  // Datapath widths.
  localparam int unsigned POS_W  = 41;
  localparam int unsigned PROD_W = 58;
  localparam int unsigned ACC_W  = 68;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_OFFSET    = 3'd0,
    CFG_SPD_ALPHA = 3'd1,
    CFG_CUR_ALPHA = 3'd2,
    CFG_SPD_SCALE = 3'd3,
    CFG_POS_SCALE = 3'd4
  } cfg_idx_e;

  // Controller states: idle, one per shared-multiplier slot, final add, done.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_X,
    ST_XL,
    ST_XH,
    ST_SOLD,
    ST_CNEW,
    ST_COLD,
    ST_PLO,
    ST_PHI,
    ST_ACC,
    ST_DONE
  } ctrl_state_e;

  // Operand selection of the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_SPD_X,
    MUL_SPD_XL,
    MUL_SPD_XH,
    MUL_SPD_OLD,
    MUL_CUR_NEW,
    MUL_CUR_OLD,
    MUL_POS_LO,
    MUL_POS_HI
  } mul_sel_e;

  // Accumulator operation on the previous product.
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_SH24,
    ACC_LOAD_SH16,
    ACC_ADD_SH20
  } acc_op_e;

  typedef struct packed {
    logic     accept;
    logic     load_pos;
    logic     save_x;
    logic     save_spd;
    logic     save_cur;
    logic     load_out;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
  } dp_cmd_t;

endpackage

// File: sv/mfd_ctrl.sv
// Sequencer of the motor feedback decoder: steps the shared multiplier
// schedule and owns the channel handshake. Depends on mfd_pkg.
module mfd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mfd_pkg::dp_cmd_t cmd_o
);
  import mfd_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) || !rst_ni;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.acc_op  = ACC_HOLD;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = ST_X;
      end
      ST_X: begin
        cmd_o.mul_sel  = MUL_SPD_X;
        cmd_o.load_pos = 1'b1;
        state_d        = ST_XL;
      end
      ST_XL: begin
        cmd_o.mul_sel = MUL_SPD_XL;
        cmd_o.save_x  = 1'b1;
        state_d       = ST_XH;
      end
      ST_XH: begin
        cmd_o.mul_sel = MUL_SPD_XH;
        cmd_o.acc_op  = ACC_LOAD;
        state_d       = ST_SOLD;
      end
      ST_SOLD: begin
        cmd_o.mul_sel = MUL_SPD_OLD;
        cmd_o.acc_op  = ACC_ADD_SH24;
        state_d       = ST_CNEW;
      end
      ST_CNEW: begin
        cmd_o.mul_sel = MUL_CUR_NEW;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_COLD;
      end
      ST_COLD: begin
        cmd_o.mul_sel  = MUL_CUR_OLD;
        cmd_o.acc_op   = ACC_LOAD_SH16;
        cmd_o.save_spd = 1'b1;
        state_d        = ST_PLO;
      end
      ST_PLO: begin
        cmd_o.mul_sel = MUL_POS_LO;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_PHI;
      end
      ST_PHI: begin
        cmd_o.mul_sel  = MUL_POS_HI;
        cmd_o.acc_op   = ACC_LOAD;
        cmd_o.save_cur = 1'b1;
        state_d        = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_op = ACC_ADD_SH20;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: sv/mfd_dp.sv
// Datapath of the motor feedback decoder: config registers, turn counter,
// shared multiplier, accumulator, filter state and output registers. Uses mfd_pkg.
module mfd_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mfd_pkg::dp_cmd_t    cmd_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i,
  input  logic [7:0]          angle_high_i,
  input  logic [7:0]          angle_low_i,
  input  logic [7:0]          speed_high_i,
  input  logic [7:0]          speed_low_i,
  input  logic [7:0]          current_high_i,
  input  logic [7:0]          current_low_i,
  input  logic [7:0]          temperature_byte_i,
  output logic [15:0]         encoder_count_o,
  output logic signed [23:0]  turns_o,
  output logic signed [31:0]  speed_smoothed_o,
  output logic signed [31:0]  current_smoothed_o,
  output logic [7:0]          temperature_o,
  output logic signed [47:0]  multiturn_angle_o,
  output logic signed [32:0]  wrapped_angle_o
);
  import mfd_pkg::*;

  // Configuration
  logic [12:0] offset_q;
  logic [16:0] spd_alpha_q, cur_alpha_q;
  logic [23:0] spd_scale_q, pos_scale_q;

  // Item state
  logic [15:0]        prev_q;
  logic [23:0]        turn_q, turn_d;
  logic signed [31:0] spd_filt_q, cur_filt_q;
  logic [15:0]        spd_raw_q, cur_raw_q;
  logic [7:0]         temp_q;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [39:0]        x_q;

  // Shared multiplier and accumulator
  logic signed [24:0]       op_a;
  logic signed [32:0]       op_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  prod_ext, acc_q, acc_d;

  logic [15:0]        count_in;
  logic [16:0]        diff;
  logic [16:0]        a_s, a_c, na_s, na_c;
  logic signed [ACC_W-1:0] rnd, shd;
  logic signed [31:0] filt_sat;
  logic signed [47:0] total;
  logic [31:0]        wlow;
  logic signed [32:0] wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= RST_OFFSET;
      spd_alpha_q <= ALPHA_ONE;
      cur_alpha_q <= ALPHA_ONE;
      spd_scale_q <= RST_SPD_SCALE;
      pos_scale_q <= RST_POS_SCALE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_OFFSET:    offset_q    <= cfg_data_i[12:0];
        CFG_SPD_ALPHA: spd_alpha_q <= cfg_data_i[16:0];
        CFG_CUR_ALPHA: cur_alpha_q <= cfg_data_i[16:0];
        CFG_SPD_SCALE: spd_scale_q <= cfg_data_i;
        CFG_POS_SCALE: pos_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Turn detection on the raw count step
  assign count_in = {angle_high_i, angle_low_i};
  assign diff     = {1'b0, count_in} - {1'b0, prev_q};

  always_comb begin
    turn_d = turn_q;
    if ($signed(diff) > HALF_TURN) turn_d = turn_q - 24'd1;
    else if ($signed(diff) < -HALF_TURN) turn_d = turn_q + 24'd1;
  end

  // Multi-turn count relative to the zero point
  assign pos_d = ({{(POS_W-24){turn_q[23]}}, turn_q} * {{(POS_W-16){1'b0}}, TURN_MULT})
               + {{(POS_W-16){1'b0}}, prev_q} - {{(POS_W-13){1'b0}}, offset_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      turn_q     <= '0;
      spd_filt_q <= '0;
      cur_filt_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        prev_q <= count_in;
        turn_q <= turn_d;
      end
      if (cmd_i.save_spd) spd_filt_q <= filt_sat;
      if (cmd_i.save_cur) cur_filt_q <= filt_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      spd_raw_q <= {speed_high_i, speed_low_i};
      cur_raw_q <= {current_high_i, current_low_i};
      temp_q    <= temperature_byte_i;
    end
    if (cmd_i.load_pos) pos_q <= pos_d;
    if (cmd_i.save_x)   x_q   <= prod_q[39:0];
    prod_q <= op_a * op_b;
    acc_q  <= acc_d;
  end

  // Weights clamp at one
  assign a_s  = (spd_alpha_q > ALPHA_ONE) ? ALPHA_ONE : spd_alpha_q;
  assign a_c  = (cur_alpha_q > ALPHA_ONE) ? ALPHA_ONE : cur_alpha_q;
  assign na_s = ALPHA_ONE - a_s;
  assign na_c = ALPHA_ONE - a_c;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_sel)
      MUL_SPD_X: begin
        op_a = {spd_scale_q[23], spd_scale_q};
        op_b = {{17{spd_raw_q[15]}}, spd_raw_q};
      end
      MUL_SPD_XL: begin
        op_a = {8'd0, a_s};
        op_b = {9'd0, prod_q[23:0]};
      end
      MUL_SPD_XH: begin
        op_a = {8'd0, a_s};
        op_b = {{17{x_q[39]}}, x_q[39:24]};
      end
      MUL_SPD_OLD: begin
        op_a = {8'd0, na_s};
        op_b = {spd_filt_q[31], spd_filt_q};
      end
      MUL_CUR_NEW: begin
        op_a = {8'd0, a_c};
        op_b = {{17{cur_raw_q[15]}}, cur_raw_q};
      end
      MUL_CUR_OLD: begin
        op_a = {8'd0, na_c};
        op_b = {cur_filt_q[31], cur_filt_q};
      end
      MUL_POS_LO: begin
        op_a = {1'b0, pos_scale_q};
        op_b = {13'd0, pos_q[19:0]};
      end
      MUL_POS_HI: begin
        op_a = {1'b0, pos_scale_q};
        op_b = {{(33-(POS_W-20)){pos_q[POS_W-1]}}, pos_q[POS_W-1:20]};
      end
      default: ;
    endcase
  end

  assign prod_ext = $signed({{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});

  always_comb begin
    case (cmd_i.acc_op)
      ACC_LOAD:      acc_d = prod_ext;
      ACC_ADD:       acc_d = acc_q + prod_ext;
      ACC_ADD_SH24:  acc_d = acc_q + (prod_ext <<< 24);
      ACC_LOAD_SH16: acc_d = prod_ext <<< 16;
      ACC_ADD_SH20:  acc_d = acc_q + (prod_ext <<< 20);
      default:       acc_d = acc_q;
    endcase
  end

  // Round half up, drop 16 fraction bits, saturate to 32 bits
  assign rnd = acc_q + $signed({{(ACC_W-16){1'b0}}, 16'h8000});
  assign shd = rnd >>> 16;
  assign filt_sat = (shd[ACC_W-1:31] == {(ACC_W-31){shd[31]}}) ? shd[31:0]
                  : (shd[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  // Saturate the angle to 48 bits and wrap it into one revolution
  assign total = (acc_q[ACC_W-1:47] == {(ACC_W-47){acc_q[47]}}) ? acc_q[47:0]
               : (acc_q[ACC_W-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});
  assign wlow = total[31:0];
  assign wrap = (wlow[31] && (wlow[30:0] != 31'd0)) ? {1'b1, wlow} : {1'b0, wlow};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      encoder_count_o    <= prev_q;
      turns_o            <= turn_q;
      speed_smoothed_o   <= spd_filt_q;
      current_smoothed_o <= cur_filt_q;
      temperature_o      <= temp_q;
      multiturn_angle_o  <= total;
      wrapped_angle_o    <= wrap;
    end
  end

endmodule

// File: sv/motor_feedback_decoder.sv
// Motor feedback decoder, top level: handshake, sequencer and datapath.
// Depends on mfd_pkg, mfd_ctrl and mfd_dp.
//
// Usage:
//  - Input channel: one beat is one seven-byte feedback frame (big-endian
//    angle, signed speed, signed current, temperature). A beat is taken on a
//    rising edge with in_valid_i high and in_stall_o low.
//  - Output channel: one beat per frame, held in an output register until
//    taken with out_valid_o high and out_stall_i low.
//  - Sequencing: one frame at a time; the input stays stalled until the
//    single 25x33 shared multiplier has run eight products for the frame,
//    plus the final add, and the result is loaded into the output register.
//  - A new frame is taken while the previous result still waits in the
//    output register; if the receiver keeps stalling, the next result
//    waits in the datapath and the input stays stalled until the slot frees.
//  - Configuration: write cfg_data_i to register cfg_index_i with cfg_we_i,
//    only while idle. Unknown indexes are dropped.
//  - Reset (rst_ni low, asynchronous): registers return to their defaults,
//    turn counter, last count and both filters clear, no result is shown.
module motor_feedback_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         angle_high_i,
  input  logic [7:0]         angle_low_i,
  input  logic [7:0]         speed_high_i,
  input  logic [7:0]         speed_low_i,
  input  logic [7:0]         current_high_i,
  input  logic [7:0]         current_low_i,
  input  logic [7:0]         temperature_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        encoder_count_o,
  output logic signed [23:0] turns_o,
  output logic signed [31:0] speed_smoothed_o,
  output logic signed [31:0] current_smoothed_o,
  output logic [7:0]         temperature_o,
  output logic signed [47:0] multiturn_angle_o,
  output logic signed [32:0] wrapped_angle_o
);
  import mfd_pkg::*;

  // Command bundle from the sequencer; one field group per datapath unit.
  dp_cmd_t cmd;

  // Sequencer: walks the multiplier schedule, owns both valid/stall pairs.
  mfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Datapath: turn counting at input acceptance, then the IIR updates and
  // the scaled angle through one shared multiplier and accumulator.
  mfd_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .angle_high_i       (angle_high_i),
    .angle_low_i        (angle_low_i),
    .speed_high_i       (speed_high_i),
    .speed_low_i        (speed_low_i),
    .current_high_i     (current_high_i),
    .current_low_i      (current_low_i),
    .temperature_byte_i (temperature_byte_i),
    .encoder_count_o    (encoder_count_o),
    .turns_o            (turns_o),
    .speed_smoothed_o   (speed_smoothed_o),
    .current_smoothed_o (current_smoothed_o),
    .temperature_o      (temperature_o),
    .multiturn_angle_o  (multiturn_angle_o),
    .wrapped_angle_o    (wrapped_angle_o)
  );

endmodule

// File: sv/mfd_checker.sv
// Port-level checks of the motor feedback decoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [47:0] multiturn_angle_o,
  input logic [32:0] wrapped_angle_o
);

  // A stalled result stays valid and its multi-turn angle unchanged.
  `MFD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(multiturn_angle_o), "stalled result changed")

  // One frame at a time: the input stalls right after a beat is taken.
  `MFD_ASSERT(a_busy_after_take, in_valid_i && !in_stall_o |=> in_stall_o, "frame taken while busy")

  // Wrapped angle shares the low 32 bits of the multi-turn angle.
  `MFD_ASSERT(a_wrap_low, out_valid_o |-> wrapped_angle_o[31:0] == multiturn_angle_o[31:0], "wrap low bits differ")

  // Wrapped angle is negative exactly above pi.
  `MFD_ASSERT(a_wrap_sign, out_valid_o |-> wrapped_angle_o[32] == (multiturn_angle_o[31] && (multiturn_angle_o[30:0] != 31'd0)), "wrap sign wrong")

  // No result during reset.
  `MFD_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "result shown in reset")

endmodule

bind motor_feedback_decoder mfd_checker u_mfd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .multiturn_angle_o (multiturn_angle_o),
  .wrapped_angle_o   (wrapped_angle_o)
);
